// File: design/fte_pkg.sv
// Shared types, codes and constants for the FAT table entry engine.
// No dependencies; fte_store, fte_ctrl and the top level import this package.
`default_nettype none

package fte_pkg;

    // Default geometry, handed to the top-level parameters.
    localparam int DEF_SECTOR_BYTES    = 512;
    localparam int DEF_MAX_FAT_SECTORS = 32;

    // Fixed field widths.
    localparam int CLUSTER_W  = 16;
    localparam int VALUE_W    = 16;
    localparam int OFF_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FAT_SIXTEEN     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_FAT = 1'b1;

    // Request operations.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Entry masks.
    localparam logic [VALUE_W-1:0] MASK_LOW_NIBBLE  = 16'h000F;
    localparam logic [VALUE_W-1:0] MASK_HIGH_NIBBLE = 16'hF000;
    localparam logic [VALUE_W-1:0] MASK_ENTRY12     = 16'h0FFF;

    // Request beat.
    typedef struct packed {
        logic                 op;
        logic [CLUSTER_W-1:0] cluster;
        logic [VALUE_W-1:0]   new_value;
    } t_fte_req;

    // Result beat.
    typedef struct packed {
        logic [VALUE_W-1:0] entry_value;
        logic               out_of_range;
    } t_fte_rsp;

    // Commands from the sequencer to the byte store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } t_fte_store_ctl;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_COPY2,
        ST_DONE
    } t_fte_state;

endpackage

`default_nettype wire

// File: design/fte_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/fte_store.sv
// Byte store for both FAT copies, split into an even-byte and an odd-byte bank
// so that any two consecutive bytes are read or written together.
// Depends on fte_pkg and fte_ram.
`default_nettype none

module fte_store
    import fte_pkg::*;
#(
    parameter int SECTOR_BYTES    = DEF_SECTOR_BYTES,
    parameter int MAX_FAT_SECTORS = DEF_MAX_FAT_SECTORS
) (
    input  wire logic                                           i_clk,
    input  wire t_fte_store_ctl                                 i_ctl,
    input  wire logic [$clog2(2*MAX_FAT_SECTORS*SECTOR_BYTES)-1:0] i_rd_addr,
    input  wire logic [$clog2(2*MAX_FAT_SECTORS*SECTOR_BYTES)-1:0] i_wr_addr,
    input  wire logic [VALUE_W-1:0]                             i_wr_data,
    input  wire logic [$clog2(MAX_FAT_SECTORS*SECTOR_BYTES)-1:0]   i_clr_addr,
    output logic      [VALUE_W-1:0]                             o_rd_data
);

    localparam int BANK_DEPTH = MAX_FAT_SECTORS * SECTOR_BYTES;
    localparam int ADDR_W     = $clog2(2 * BANK_DEPTH);
    localparam int BA_W       = $clog2(BANK_DEPTH);

    logic [ADDR_W:0]   rd_sum;
    logic [ADDR_W:0]   wr_sum;
    logic [BA_W-1:0]   rd_addr0;
    logic [BA_W-1:0]   rd_addr1;
    logic [BA_W-1:0]   wr_addr0;
    logic [BA_W-1:0]   wr_addr1;
    logic [7:0]        wdata0;
    logic [7:0]        wdata1;
    logic              we;
    logic [7:0]        q0;
    logic [7:0]        q1;
    logic              r_lane;

    // The first byte sits in the bank its address bit 0 selects; the even bank
    // row is (a+1)/2 and the odd bank row is a/2 in both cases.
    always_comb begin
        rd_sum   = {1'b0, i_rd_addr} + (ADDR_W+1)'(1);
        wr_sum   = {1'b0, i_wr_addr} + (ADDR_W+1)'(1);
        rd_addr0 = BA_W'(rd_sum[ADDR_W:1]);
        rd_addr1 = BA_W'(i_rd_addr[ADDR_W-1:1]);
        wr_addr0 = BA_W'(wr_sum[ADDR_W:1]);
        wr_addr1 = BA_W'(i_wr_addr[ADDR_W-1:1]);
        we       = i_ctl.wr_en;
        if (i_wr_addr[0]) begin
            wdata1 = i_wr_data[7:0];
            wdata0 = i_wr_data[15:8];
        end else begin
            wdata0 = i_wr_data[7:0];
            wdata1 = i_wr_data[15:8];
        end
        // The clearing pass overrides normal writes.
        if (i_ctl.clr_en) begin
            we       = 1'b1;
            wr_addr0 = i_clr_addr;
            wr_addr1 = i_clr_addr;
            wdata0   = 8'h00;
            wdata1   = 8'h00;
        end
    end

    fte_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr0),
        .i_wdata (wdata0),
        .i_re    (i_ctl.rd_en),
        .i_raddr (rd_addr0),
        .o_rdata (q0)
    );

    fte_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr1),
        .i_wdata (wdata1),
        .i_re    (i_ctl.rd_en),
        .i_raddr (rd_addr1),
        .o_rdata (q1)
    );

    // Remember which bank held the first byte of the read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_lane <= i_rd_addr[0];
        end
    end

    // Reassemble the little-endian byte pair.
    assign o_rd_data = r_lane ? {q0, q1} : {q1, q0};

endmodule

`default_nettype wire

// File: design/fte_ctrl.sv
// Request sequencer: offset and range check, read-modify-write of the entry
// in both copies, clearing pass after reset and the result register.
// Depends on fte_pkg.
`default_nettype none

module fte_ctrl
    import fte_pkg::*;
#(
    parameter int SECTOR_BYTES    = DEF_SECTOR_BYTES,
    parameter int MAX_FAT_SECTORS = DEF_MAX_FAT_SECTORS
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_in_valid,
    output logic                                                o_in_ready,
    input  wire t_fte_req                                       i_in_data,
    output logic                                                o_out_valid,
    input  wire logic                                           i_out_ready,
    output t_fte_rsp                                            o_out_data,
    input  wire logic                                           i_fat_sixteen,
    input  wire logic [$clog2(2*MAX_FAT_SECTORS*SECTOR_BYTES)-1:0] i_span,
    output t_fte_store_ctl                                      o_store_ctl,
    output logic      [$clog2(2*MAX_FAT_SECTORS*SECTOR_BYTES)-1:0] o_rd_addr,
    output logic      [$clog2(2*MAX_FAT_SECTORS*SECTOR_BYTES)-1:0] o_wr_addr,
    output logic      [VALUE_W-1:0]                             o_wr_data,
    output logic      [$clog2(MAX_FAT_SECTORS*SECTOR_BYTES)-1:0]   o_clr_addr,
    input  wire logic [VALUE_W-1:0]                             i_rd_data
);

    localparam int BANK_DEPTH = MAX_FAT_SECTORS * SECTOR_BYTES;
    localparam int ADDR_W     = $clog2(2 * BANK_DEPTH);
    localparam int BA_W       = $clog2(BANK_DEPTH);
    localparam int CMP_W      = (ADDR_W > OFF_W + 1) ? ADDR_W : OFF_W + 1;

    t_fte_state         r_state;
    t_fte_state         n_state;
    logic [BA_W-1:0]    r_clr_addr;
    logic               r_op;
    logic               r_odd;
    logic               r_wide;
    logic [VALUE_W-1:0] r_nv;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_oor;
    logic [VALUE_W-1:0] r_result;
    logic [VALUE_W-1:0] r_merged;
    t_fte_rsp           r_out;
    logic               r_out_valid;

    logic               accept;
    logic               clr_last;
    logic               slot_free;
    logic               load_now;
    logic               load_held;
    logic [OFF_W-1:0]   off;
    logic               oor;
    logic [VALUE_W-1:0] nv_masked;
    logic [VALUE_W-1:0] result;
    logic [VALUE_W-1:0] merged;

    assign accept    = (r_state == ST_IDLE) && i_in_valid;
    assign clr_last  = (r_clr_addr == BA_W'(BANK_DEPTH - 1));
    assign slot_free = !r_out_valid || i_out_ready;

    // Byte offset of the entry and the range check against one copy.
    always_comb begin
        if (i_fat_sixteen) begin
            off = {i_in_data.cluster, 1'b0};
        end else begin
            off = {1'b0, i_in_data.cluster} + {2'b00, i_in_data.cluster[15:1]};
        end
        oor       = (CMP_W'(off) + CMP_W'(1)) >= CMP_W'(i_span);
        nv_masked = i_fat_sixteen ? i_in_data.new_value
                                  : (i_in_data.new_value & MASK_ENTRY12);
    end

    // Entry extraction and nibble merge on the byte pair just read.
    always_comb begin
        if (r_op == OP_WRITE) begin
            result = r_nv;
            if (r_wide) begin
                merged = r_nv;
            end else if (r_odd) begin
                merged = (i_rd_data & MASK_LOW_NIBBLE) | {r_nv[11:0], 4'h0};
            end else begin
                merged = (i_rd_data & MASK_HIGH_NIBBLE) | r_nv;
            end
        end else begin
            merged = i_rd_data;
            if (r_wide) begin
                result = i_rd_data;
            end else if (r_odd) begin
                result = {4'h0, i_rd_data[15:4]};
            end else begin
                result = i_rd_data & MASK_ENTRY12;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = oor ? ST_DONE : ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (r_op == OP_WRITE) begin
                    n_state = ST_COPY2;
                end else begin
                    n_state = slot_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_COPY2: begin
                n_state = slot_free ? ST_IDLE : ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Store commands and result loading per state.
    always_comb begin
        o_store_ctl = '0;
        o_rd_addr   = r_addr;
        o_wr_addr   = r_addr;
        o_wr_data   = merged;
        o_in_ready  = 1'b0;
        load_now    = 1'b0;
        load_held   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_store_ctl.clr_en = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_READ: begin
                o_store_ctl.rd_en = 1'b1;
            end
            ST_MODIFY: begin
                if (r_op == OP_WRITE) begin
                    o_store_ctl.wr_en = 1'b1;
                end else begin
                    load_now = slot_free;
                end
            end
            ST_COPY2: begin
                // Second copy starts one copy length further on.
                o_store_ctl.wr_en = 1'b1;
                o_wr_addr         = i_span + r_addr;
                o_wr_data         = r_merged;
                load_held         = slot_free;
            end
            ST_DONE: begin
                load_held = slot_free;
            end
            default: begin
                o_store_ctl = '0;
            end
        endcase
    end

    assign o_clr_addr = r_clr_addr;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + BA_W'(1);
            end
            if (load_now || load_held) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_in_data.op;
            r_odd    <= i_in_data.cluster[0];
            r_wide   <= i_fat_sixteen;
            r_nv     <= nv_masked;
            r_addr   <= ADDR_W'(CMP_W'(off));
            r_oor    <= oor;
            r_result <= '0;
        end
        if (r_state == ST_MODIFY) begin
            r_result <= result;
            r_merged <= merged;
        end
        if (load_now) begin
            r_out.entry_value  <= result;
            r_out.out_of_range <= 1'b0;
        end else if (load_held) begin
            r_out.entry_value  <= r_result;
            r_out.out_of_range <= r_oor;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: design/fat_table_entry_engine.sv
// Top level of the FAT table entry engine: configuration registers,
// sequencer and two-bank byte store. Depends on fte_pkg, fte_ctrl, fte_store.
`default_nettype none

// Reads or writes one FAT12 or FAT16 table entry per request beat and returns
// one result beat. After reset the byte store is swept to zero, one row of
// both banks per cycle, over all MAX_FAT_SECTORS*SECTOR_BYTES rows (16384 at the
// default geometry); no request is taken meanwhile, but configuration writes
// are. After that a read passes through ST_READ and ST_MODIFY, a write through
// ST_READ, ST_MODIFY and ST_COPY2, and an out-of-range request goes straight
// to ST_DONE; the next request is taken on the cycle after the result is
// registered, while that result may still be waiting at the output. These
// steps come from the registered read of the store and from each bank
// having a single write port, so the second FAT copy is written in the
// cycle after the first. Configuration registers are written through
// i_cfg_we/i_cfg_idx/i_cfg_data while no request is in flight; the user must
// keep to this, as the block itself does not enforce it.
module fat_table_entry_engine
    import fte_pkg::*;
#(
    parameter int SECTOR_BYTES    = DEF_SECTOR_BYTES,
    parameter int MAX_FAT_SECTORS = DEF_MAX_FAT_SECTORS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_fte_req              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_fte_rsp                   o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int BANK_DEPTH = MAX_FAT_SECTORS * SECTOR_BYTES;
    localparam int ADDR_W     = $clog2(2 * BANK_DEPTH);
    localparam int BA_W       = $clog2(BANK_DEPTH);
    localparam int SEC_W      = 9;

    logic               r_fat_sixteen;
    logic [ADDR_W-1:0]  r_span;
    logic [SEC_W-1:0]   sec_sat;
    logic [ADDR_W-1:0]  n_span;

    t_fte_store_ctl     store_ctl;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [BA_W-1:0]    clr_addr;
    logic [VALUE_W-1:0] rd_data;

    // Sector count saturates at the store size; one copy's length is kept.
    always_comb begin
        if ({{(SEC_W-CFG_DATA_W){1'b0}}, i_cfg_data} > SEC_W'(MAX_FAT_SECTORS)) begin
            sec_sat = SEC_W'(MAX_FAT_SECTORS);
        end else begin
            sec_sat = {{(SEC_W-CFG_DATA_W){1'b0}}, i_cfg_data};
        end
        n_span = ADDR_W'(sec_sat * SECTOR_BYTES);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fat_sixteen <= 1'b0;
            r_span        <= ADDR_W'(SECTOR_BYTES);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FAT_SIXTEEN: begin
                    r_fat_sixteen <= i_cfg_data[0];
                end
                CFG_SECTORS_PER_FAT: begin
                    r_span <= n_span;
                end
                default: begin
                    r_span <= r_span;
                end
            endcase
        end
    end

    fte_ctrl #(
        .SECTOR_BYTES    (SECTOR_BYTES),
        .MAX_FAT_SECTORS (MAX_FAT_SECTORS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data),
        .i_fat_sixteen (r_fat_sixteen),
        .i_span        (r_span),
        .o_store_ctl   (store_ctl),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_clr_addr    (clr_addr),
        .i_rd_data     (rd_data)
    );

    fte_store #(
        .SECTOR_BYTES    (SECTOR_BYTES),
        .MAX_FAT_SECTORS (MAX_FAT_SECTORS)
    ) u_store (
        .i_clk      (i_clk),
        .i_ctl      (store_ctl),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_clr_addr (clr_addr),
        .o_rd_data  (rd_data)
    );

endmodule

`default_nettype wire
